// ----- rtl/longest_increasing_subsequence_macros.svh -----
// Assertion macros used by the datapath of the increasing-subsequence engine.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_MACROS_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LIS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lis_pkg.sv -----
// ----------------------------------------------------------------------------
// lis_pkg
// Shared constants, FSM states and controller/datapath interface structs for
// the longest-increasing-subsequence engine.
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int LEN_W        = 7;
    localparam int VAL_W        = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ROW,
        ST_VI,
        ST_SCAN,
        ST_WRITE,
        ST_WINIT,
        ST_WRD,
        ST_WSTEP,
        ST_ERD1,
        ST_ERD2,
        ST_EOUT
    } t_lis_state;

    typedef struct packed {
        logic load;
        logic row;
        logic vi;
        logic scan;
        logic row_wr;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic emit_rd1;
        logic emit_rd2;
        logic emit_out;
    } t_lis_cmd;

    typedef struct packed {
        logic scan_done;
        logic rows_done;
        logic walk_end;
        logic emit_last;
        logic out_free;
    } t_lis_status;

endpackage

// ----- rtl/longest_increasing_subsequence.sv -----
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// Loads a signed sequence, finds its longest strictly increasing subsequence
// by quadratic DP and emits it in position order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_element_value, i_is_final
//  out     | output    | o_out_valid / i_out_stall  | o_sub_value, o_run_end,
//          |           |                            | o_sub_length, o_overflowed
//
//  Loading accepts one item per cycle. Then element i gets row read, value
//  latch, one compare a cycle against each earlier element on the single
//  comparator and value memory port, a drain step and write-back; the
//  walk-back a setup step, then a read and step per result; emission a path
//  read, value read and output load per result, waiting out output stall. The
//  input is stalled from the final item until the last result is in the output
//  register. Reset is synchronous, active low; it clears the element count,
//  overflow flag, scan data-valid, controller state and output valid only.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lis_pkg::VAL_W-1:0]   i_element_value,
    input  logic                        i_is_final,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lis_pkg::VAL_W-1:0]   o_sub_value,
    output logic                        o_run_end,
    output logic [lis_pkg::LEN_W-1:0]   o_sub_length,
    output logic                        o_overflowed
);
    import lis_pkg::*;

    t_lis_cmd    cmd;
    t_lis_status sts;

    lis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_final (i_is_final),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lis_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_element_value (i_element_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_sub_value     (o_sub_value),
        .o_run_end       (o_run_end),
        .o_sub_length    (o_sub_length),
        .o_overflowed    (o_overflowed)
    );

endmodule

// ----- rtl/lis_ctrl.sv -----
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer: load, per-element scan, path walk-back and result emission.
// ----------------------------------------------------------------------------
module lis_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_is_final,
    output logic                 o_in_stall,
    input  lis_pkg::t_lis_status i_sts,
    output lis_pkg::t_lis_cmd    o_cmd
);
    import lis_pkg::*;

    t_lis_state r_state;
    t_lis_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_LOAD);
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_is_final) n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                o_cmd.row = 1'b1;
                n_state   = ST_VI;
            end
            ST_VI: begin
                o_cmd.vi = 1'b1;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_cmd.row_wr = 1'b1;
                n_state      = i_sts.rows_done ? ST_WINIT : ST_ROW;
            end
            ST_WINIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = ST_WRD;
            end
            ST_WRD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = ST_WSTEP;
            end
            ST_WSTEP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = i_sts.walk_end ? ST_ERD1 : ST_WRD;
            end
            ST_ERD1: begin
                o_cmd.emit_rd1 = 1'b1;
                n_state        = ST_ERD2;
            end
            ST_ERD2: begin
                o_cmd.emit_rd2 = 1'b1;
                n_state        = ST_EOUT;
            end
            ST_EOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_out = 1'b1;
                    n_state        = i_sts.emit_last ? ST_LOAD : ST_ERD1;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/lis_datapath.sv -----
// ----------------------------------------------------------------------------
// lis_datapath
// Element, length, link and path memories, one shared signed comparator,
// scan/walk/emit counters and the output register.
// ----------------------------------------------------------------------------
`include "longest_increasing_subsequence_macros.svh"

module lis_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lis_pkg::t_lis_cmd           i_cmd,
    output lis_pkg::t_lis_status        o_sts,
    input  logic [lis_pkg::VAL_W-1:0]   i_element_value,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [lis_pkg::VAL_W-1:0]   o_sub_value,
    output logic                        o_run_end,
    output logic [lis_pkg::LEN_W-1:0]   o_sub_length,
    output logic                        o_overflowed
);
    import lis_pkg::*;

    // memories
    logic [VAL_W-1:0] value_store [MAX_ELEMENTS];
    logic [LEN_W-1:0] best_length [MAX_ELEMENTS];
    logic [IDX_W-1:0] predecessor [MAX_ELEMENTS];
    logic [IDX_W-1:0] path_stack  [MAX_ELEMENTS];

    // registered read data
    logic [VAL_W-1:0] r_rd_value;
    logic [LEN_W-1:0] r_rd_len;
    logic [IDX_W-1:0] r_rd_pred;
    logic [IDX_W-1:0] r_rd_path;

    // control state
    logic [LEN_W-1:0] r_load_count;
    logic             r_ovf;
    logic             r_dv;
    logic             r_out_valid;

    // working registers
    logic [IDX_W-1:0] r_i;
    logic [IDX_W-1:0] r_j;
    logic [IDX_W-1:0] r_jd;
    logic [VAL_W-1:0] r_vi;
    logic [LEN_W-1:0] r_len;
    logic [IDX_W-1:0] r_prev;
    logic [LEN_W-1:0] r_top_len;
    logic [IDX_W-1:0] r_top_pos;
    logic [IDX_W-1:0] r_pos;
    logic [LEN_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_k;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_end;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_ovf;

    logic             issue;
    logic             longer;
    logic [IDX_W-1:0] val_addr;
    logic [IDX_W-1:0] len_addr;
    logic [LEN_W-1:0] emit_idx;

    assign issue    = (i_cmd.vi || i_cmd.scan) && (r_j != r_i);
    assign longer   = ($signed(r_rd_value) < $signed(r_vi)) &&
                      ((r_rd_len + LEN_W'(1)) > r_len);
    assign val_addr = i_cmd.row ? r_i : (i_cmd.emit_rd2 ? r_rd_path : r_j);
    assign len_addr = i_cmd.walk_rd ? r_pos : r_j;
    assign emit_idx = r_cnt - LEN_W'(1) - LEN_W'(r_k);

    assign o_sts.scan_done = (r_j == r_i) && !r_dv;
    assign o_sts.rows_done = (LEN_W'(r_i) + LEN_W'(1)) == r_load_count;
    assign o_sts.walk_end  = (r_rd_len <= LEN_W'(1));
    assign o_sts.emit_last = (LEN_W'(r_k) + LEN_W'(1)) == r_cnt;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_load_count < LEN_W'(MAX_ELEMENTS))) begin
            value_store[r_load_count[IDX_W-1:0]] <= i_element_value;
        end
        // hold the read data while an emitted item waits on the output
        if (i_cmd.row || issue || i_cmd.emit_rd2) begin
            r_rd_value <= value_store[val_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            best_length[r_i] <= r_len;
            predecessor[r_i] <= r_prev;
        end
        r_rd_len  <= best_length[len_addr];
        r_rd_pred <= predecessor[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step) begin
            path_stack[r_cnt[IDX_W-1:0]] <= r_pos;
        end
        if (i_cmd.emit_rd1) begin
            r_rd_path <= path_stack[emit_idx[IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
            r_ovf        <= 1'b0;
            r_dv         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_dv <= issue;
            if (i_cmd.load) begin
                if (r_load_count < LEN_W'(MAX_ELEMENTS)) begin
                    r_load_count <= r_load_count + LEN_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.emit_out) begin
                r_out_valid <= 1'b1;
                // sequence done: start a fresh one
                if (o_sts.emit_last) begin
                    r_load_count <= '0;
                    r_ovf        <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_i       <= '0;
            r_top_len <= '0;
        end
        if (i_cmd.row) begin
            r_j    <= '0;
            r_len  <= LEN_W'(1);
            r_prev <= '0;
        end
        if (i_cmd.vi) begin
            r_vi <= r_rd_value;
        end
        if (issue) begin
            r_j <= r_j + IDX_W'(1);
        end
        r_jd <= r_j;
        // strictly longer only: ties keep the earliest predecessor
        if (i_cmd.scan && r_dv && longer) begin
            r_len  <= r_rd_len + LEN_W'(1);
            r_prev <= r_jd;
        end
        if (i_cmd.row_wr) begin
            r_i <= r_i + IDX_W'(1);
            if (r_len >= r_top_len) begin
                r_top_len <= r_len;
                r_top_pos <= r_i;
            end
        end
        if (i_cmd.walk_init) begin
            r_pos <= r_top_pos;
            r_cnt <= '0;
            r_k   <= '0;
        end
        if (i_cmd.walk_step) begin
            r_cnt <= r_cnt + LEN_W'(1);
            r_pos <= r_rd_pred;
        end
        if (i_cmd.emit_out) begin
            r_k         <= r_k + IDX_W'(1);
            r_out_value <= r_rd_value;
            r_out_end   <= o_sts.emit_last;
            r_out_len   <= r_cnt;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sub_value  = r_out_value;
    assign o_run_end    = r_out_end;
    assign o_sub_length = r_out_len;
    assign o_overflowed = r_out_ovf;

    `LIS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_load_count <= LEN_W'(MAX_ELEMENTS), "load count above capacity")
    `LIS_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, r_ovf, r_load_count == LEN_W'(MAX_ELEMENTS), "overflow flagged with free space")
    `LIS_ASSERT_NOW(a_len_bound, i_clk, i_rst_n, i_cmd.scan, r_len <= (LEN_W'(r_i) + LEN_W'(1)), "chain longer than its prefix")
    `LIS_ASSERT_NOW(a_path_len, i_clk, i_rst_n, i_cmd.emit_out, r_cnt == r_top_len, "walked path length differs from best length")
    `LIS_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.emit_out, r_out_valid, "emitted item not presented")

endmodule
